// ----- src/crep_pkg.sv -----
`timescale 1ns / 1ps
package crep_pkg;

    localparam int DEF_LOG_DEPTH   = 1024;
    localparam int DEF_MAX_NODES   = 16;
    localparam int DEF_APPLY_BURST = 32;

    localparam int IDX_W   = 11;
    localparam int TERM_W  = 32;
    localparam int ID_W    = 5;
    localparam int CNT_W   = 6;
    localparam int RES_MAX = 48;
    localparam int QDEPTH  = 2;

    localparam logic [31:0] TERM_SAT = 32'hFFFF_FFFF;

    localparam logic [2:0] FN_VOTE_REQ = 3'd0;
    localparam logic [2:0] FN_APPEND   = 3'd1;
    localparam logic [2:0] FN_TIMEOUT  = 3'd2;
    localparam logic [2:0] FN_VOTE_REP = 3'd3;
    localparam logic [2:0] FN_PROPOSE  = 3'd4;
    localparam logic [2:0] FN_ACK      = 3'd5;
    localparam logic [2:0] FN_TICK     = 3'd6;

    localparam logic [2:0] K_VOTE_REP   = 3'd0;
    localparam logic [2:0] K_APPEND_REP = 3'd1;
    localparam logic [2:0] K_APPLY      = 3'd2;
    localparam logic [2:0] K_APPEND_REQ = 3'd3;
    localparam logic [2:0] K_VOTE_REQ   = 3'd4;
    localparam logic [2:0] K_PROP_ANS   = 3'd5;

    localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [1:0] ROLE_LEADER    = 2'd2;

    localparam logic REG_OWN_ID  = 1'b0;
    localparam logic REG_CLUSTER = 1'b1;

    typedef enum logic [2:0] {
        OP_VOTE_REQ,
        OP_APPEND,
        OP_TIMEOUT,
        OP_VOTE_REP,
        OP_PROPOSE,
        OP_ACK,
        OP_TICK,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [TERM_W-1:0] msg_term;
        logic [ID_W-1:0]   peer;
        logic [IDX_W-1:0]  ref_index;
        logic [TERM_W-1:0] ref_term;
        logic [IDX_W-1:0]  leader_commit;
        logic              has_entry;
        logic [TERM_W-1:0] entry_term;
        logic [31:0]       payload;
        logic              granted;
    } item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic              ok;
        logic [IDX_W-1:0]  out_index;
        logic [TERM_W-1:0] out_term;
        logic [ID_W-1:0]   dest;
        logic [31:0]       out_payload;
        logic [IDX_W-1:0]  out_commit;
    } res_t;

    typedef struct packed {
        logic not_full;
        logic has_data;
    } q_stat_t;

endpackage

// ----- src/consensus_replica_engine_unit.sv -----
`timescale 1ns / 1ps
// Consensus replica engine: holds the term, vote, role, log, commit and
// applied indices and per-peer replication state of one cluster member.
// Input channel (in_valid/in_ready) takes one event beat per item; the
// output channel (out_valid/out_ready) gives the result beats of that item
// in order, the final one flagged by last. Items that cause no result give
// no beat at all.
// An input stage and a two-entry queue sit in front of the sequencer, so
// new beats are taken while the sequencer works and while a result waits.
// Each item passes through dispatch, then one log read and one emit per
// result beat; a conflict back-off reads one log entry per entry walked
// back and a commit scan one per index tested. These walks over the
// log memory and its one read port set the rate.
// A stalled receiver holds the output register; the sequencer then waits
// at its next result and the input side fills up and drops in_ready.
// Reset clears all control state: term zero, follower, empty log, own_id
// and cluster_size both one; the log memory is not cleared. Write own_id
// or cluster_size via the configuration port only when idle; not enforced.
module consensus_replica_engine_unit
    import crep_pkg::*;
#(
    parameter int LOG_DEPTH   = DEF_LOG_DEPTH,
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int APPLY_BURST = DEF_APPLY_BURST
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [ID_W-1:0]   cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        func,
    input  logic [TERM_W-1:0] msg_term,
    input  logic [ID_W-1:0]   peer,
    input  logic [IDX_W-1:0]  ref_index,
    input  logic [TERM_W-1:0] ref_term,
    input  logic [IDX_W-1:0]  leader_commit,
    input  logic              has_entry,
    input  logic [TERM_W-1:0] entry_term,
    input  logic [31:0]       payload,
    input  logic              granted,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        kind,
    output logic [TERM_W-1:0] reply_term,
    output logic              ok,
    output logic [IDX_W-1:0]  out_index,
    output logic [TERM_W-1:0] out_term,
    output logic [ID_W-1:0]   dest,
    output logic [31:0]       out_payload,
    output logic [IDX_W-1:0]  out_commit,
    output logic [1:0]        role,
    output logic              last
);

    logic [ID_W-1:0] own_id_reg;
    logic [ID_W-1:0] cluster_reg;
    item_t           in_item;
    item_t           q_in;
    item_t           q_out;
    q_stat_t         q_stat;
    logic            q_push;
    logic            q_pop;
    res_t            res;

    // Write configuration registers only with no item in flight; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg  <= ID_W'(1);
            cluster_reg <= ID_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_ID:  own_id_reg  <= cfg_data;
                REG_CLUSTER: cluster_reg <= cfg_data;
                default:     own_id_reg  <= own_id_reg;
            endcase
        end
    end

    always_comb
    begin
        in_item               = '0;
        in_item.op            = OP_NONE;
        in_item.msg_term      = msg_term;
        in_item.peer          = peer;
        in_item.ref_index     = ref_index;
        in_item.ref_term      = ref_term;
        in_item.leader_commit = leader_commit;
        in_item.has_entry     = has_entry;
        in_item.entry_term    = entry_term;
        in_item.payload       = payload;
        in_item.granted       = granted;
    end

    crep_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .in_func  (func),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    crep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .stat      (q_stat)
    );

    crep_back #(
        .LOG_DEPTH   (LOG_DEPTH),
        .MAX_NODES   (MAX_NODES),
        .APPLY_BURST (APPLY_BURST)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .own_id       (own_id_reg),
        .cluster_size (cluster_reg),
        .q_stat       (q_stat),
        .q_item       (q_out),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_res      (res),
        .out_term_now (reply_term),
        .out_role     (role),
        .out_last     (last)
    );

    assign kind        = res.kind;
    assign ok          = res.ok;
    assign out_index   = res.out_index;
    assign out_term    = res.out_term;
    assign dest        = res.dest;
    assign out_payload = res.out_payload;
    assign out_commit  = res.out_commit;

endmodule

// ----- src/crep_front.sv -----
`timescale 1ns / 1ps
module crep_front
    import crep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    input  logic [2:0]  in_func,
    input  q_stat_t     q_stat,
    output logic        q_push,
    output item_t       q_item
);

    logic  stage_v_reg;
    item_t stage_reg;
    op_t   op_c;

    // Decode the selector into the operation that the back end runs.
    always_comb
    begin
        unique case (in_func)
            FN_VOTE_REQ: op_c = OP_VOTE_REQ;
            FN_APPEND:   op_c = OP_APPEND;
            FN_TIMEOUT:  op_c = OP_TIMEOUT;
            FN_VOTE_REP: op_c = OP_VOTE_REP;
            FN_PROPOSE:  op_c = OP_PROPOSE;
            FN_ACK:      op_c = OP_ACK;
            FN_TICK:     op_c = OP_TICK;
            default:     op_c = OP_NONE;
        endcase
    end

    assign q_push   = stage_v_reg && q_stat.not_full;
    assign in_ready = !stage_v_reg || q_stat.not_full;
    assign q_item   = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg    <= in_item;
            stage_reg.op <= op_c;
        end
    end

endmodule

// ----- src/crep_queue.sv -----
`timescale 1ns / 1ps
module crep_queue
    import crep_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   pop_item,
    output q_stat_t stat
);

    localparam int QAW = $clog2(QDEPTH);

    item_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.not_full = (count_reg != (QAW+1)'(QDEPTH));
    assign stat.has_data = (count_reg != '0);
    assign do_push = push && stat.not_full;
    assign do_pop  = pop && stat.has_data;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- src/crep_back.sv -----
`timescale 1ns / 1ps
module crep_back
    import crep_pkg::*;
#(
    parameter int LOG_DEPTH   = DEF_LOG_DEPTH,
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int APPLY_BURST = DEF_APPLY_BURST
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ID_W-1:0]   own_id,
    input  logic [ID_W-1:0]   cluster_size,
    input  q_stat_t           q_stat,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output res_t              out_res,
    output logic [TERM_W-1:0] out_term_now,
    output logic [1:0]        out_role,
    output logic              out_last
);

    localparam int NWR = $clog2(LOG_DEPTH + 2);
    localparam int XW  = (NWR > IDX_W) ? NWR : IDX_W;
    localparam int AW  = $clog2(LOG_DEPTH);
    localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int BW  = $clog2(APPLY_BURST + 1);

    typedef enum logic [21:0] {
        ST_IDLE   = 22'h000001,
        ST_DISP   = 22'h000002,
        ST_V_DO   = 22'h000004,
        ST_A_PT   = 22'h000008,
        ST_A_BKRD = 22'h000010,
        ST_A_BK   = 22'h000020,
        ST_A_ENT  = 22'h000040,
        ST_A_ET   = 22'h000080,
        ST_A_FIN  = 22'h000100,
        ST_VQ_EM  = 22'h000200,
        ST_LEAD   = 22'h000400,
        ST_SND_RD = 22'h000800,
        ST_SND_EM = 22'h001000,
        ST_CM_RD  = 22'h002000,
        ST_CM_CHK = 22'h004000,
        ST_PROP   = 22'h008000,
        ST_APPLY  = 22'h010000,
        ST_AP_EM  = 22'h020000,
        ST_FIN    = 22'h040000
    } state_t;

    state_t state_reg, state_next;
    item_t  item_reg;

    logic [TERM_W-1:0]  term_reg, term_next;
    logic [ID_W-1:0]    voted_reg, voted_next;
    logic [1:0]         role_reg, role_next;
    logic [XW-1:0]      len_reg, len_next;
    logic [XW-1:0]      commit_reg, commit_next;
    logic [XW-1:0]      applied_reg, applied_next;
    logic [ID_W-1:0]    votes_reg, votes_next;
    logic [MAX_NODES-1:0] vmask_reg, vmask_next;
    logic [XW-1:0]      nsend_reg [MAX_NODES];
    logic [XW-1:0]      nsend_next [MAX_NODES];
    logic [XW-1:0]      match_reg [MAX_NODES];
    logic [XW-1:0]      match_next [MAX_NODES];

    logic [CNT_W-1:0]   p_reg, p_next;
    logic [XW-1:0]      wi_reg, wi_next;
    logic [TERM_W-1:0]  ct_reg, ct_next;
    logic               ret_prop_reg, ret_prop_next;
    logic               cnt_ok_reg, cnt_ok_next;
    logic [BW-1:0]      burst_reg, burst_next;
    logic [CNT_W-1:0]   n_reg;

    logic               hold_v_reg;
    res_t               hold_reg;
    logic               out_v_reg;

    // Log storage with one write port and one registered read port.
    logic [TERM_W-1:0]  term_mem [LOG_DEPTH];
    logic [31:0]        pay_mem  [LOG_DEPTH];
    logic               we;
    logic [XW-1:0]      wr_idx;
    logic [TERM_W-1:0]  wr_term;
    logic [31:0]        wr_pay;
    logic               rd_en;
    logic [XW-1:0]      rd_idx;
    logic [TERM_W-1:0]  rd_term_reg;
    logic [31:0]        rd_pay_reg;
    logic               rd_zero_reg;
    logic [TERM_W-1:0]  rterm;
    logic [31:0]        rpay;

    logic               emit_req;
    res_t               emit_res;
    logic               emit_ok;
    logic               flush;
    logic               store;
    logic               push;
    logic               can_push;

    logic [CNT_W-1:0]   c_nodes;
    logic [CNT_W-1:0]   maj;
    logic [CNT_W-1:0]   own6;
    logic [CNT_W-1:0]   peer6;
    logic               peer_ok;
    logic               higher;
    logic [CNT_W-1:0]   match_cnt;
    logic [XW-1:0]      ri_x;
    logic [XW-1:0]      lc_x;
    logic [XW-1:0]      prev_x;
    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      lastnew;
    logic [XW-1:0]      ack_m;
    logic [XW-1:0]      np_prev;
    logic [NIW-1:0]     p_ix;
    logic [NIW-1:0]     peer_ix;

    assign rterm = rd_zero_reg ? '0 : rd_term_reg;
    assign rpay  = rd_zero_reg ? '0 : rd_pay_reg;

    always_comb
    begin
        logic [CNT_W-1:0] cs6;
        cs6 = {1'b0, cluster_size};
        if (cs6 == '0)
        begin
            c_nodes = CNT_W'(1);
        end
        else if (cs6 > CNT_W'(MAX_NODES))
        begin
            c_nodes = CNT_W'(MAX_NODES);
        end
        else
        begin
            c_nodes = cs6;
        end
    end

    assign maj     = (c_nodes >> 1) + CNT_W'(1);
    assign own6    = {1'b0, own_id};
    assign peer6   = {1'b0, item_reg.peer};
    assign peer_ok = (peer6 != '0) && (peer6 <= c_nodes) && (peer6 != own6);
    assign higher  = item_reg.msg_term > term_reg;
    assign ri_x    = XW'(item_reg.ref_index);
    assign lc_x    = XW'(item_reg.leader_commit);
    assign prev_x  = ri_x;
    assign idx_x   = prev_x + XW'(1);
    assign lastnew = prev_x + XW'(item_reg.has_entry);
    assign ack_m   = (ri_x < len_reg) ? ri_x : len_reg;
    assign p_ix    = NIW'(p_reg - CNT_W'(1));
    assign peer_ix = NIW'(peer6 - CNT_W'(1));
    assign np_prev = (nsend_reg[p_ix] != '0) ? nsend_reg[p_ix] - XW'(1) : '0;

    // Followers whose match index reaches the entry under test.
    always_comb
    begin
        match_cnt = '0;
        for (int k = 0; k < MAX_NODES; k++)
        begin
            if ((CNT_W'(k + 1) <= c_nodes) && (CNT_W'(k + 1) != own6)
                && (match_reg[k] >= wi_reg))
            begin
                match_cnt = match_cnt + CNT_W'(1);
            end
        end
    end

    assign can_push = !out_v_reg || out_ready;
    assign emit_ok  = !hold_v_reg || can_push;
    assign q_pop    = (state_reg == ST_IDLE) && q_stat.has_data;

    always_comb
    begin
        state_next    = state_reg;
        term_next     = term_reg;
        voted_next    = voted_reg;
        role_next     = role_reg;
        len_next      = len_reg;
        commit_next   = commit_reg;
        applied_next  = applied_reg;
        votes_next    = votes_reg;
        vmask_next    = vmask_reg;
        nsend_next    = nsend_reg;
        match_next    = match_reg;
        p_next        = p_reg;
        wi_next       = wi_reg;
        ct_next       = ct_reg;
        ret_prop_next = ret_prop_reg;
        cnt_ok_next   = cnt_ok_reg;
        burst_next    = burst_reg;
        emit_req      = 1'b0;
        emit_res      = '0;
        flush         = 1'b0;
        we            = 1'b0;
        wr_idx        = len_reg;
        wr_term       = item_reg.entry_term;
        wr_pay        = item_reg.payload;
        rd_en         = 1'b0;
        rd_idx        = len_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.has_data)
                begin
                    burst_next = '0;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                unique case (item_reg.op)
                    OP_VOTE_REQ:
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = len_reg;
                        state_next = ST_V_DO;
                    end
                    OP_APPEND:
                    begin
                        emit_res.kind = K_APPEND_REP;
                        if (item_reg.msg_term < term_reg)
                        begin
                            emit_req = 1'b1;
                            if (emit_ok)
                            begin
                                state_next = ST_APPLY;
                            end
                        end
                        else if ((prev_x != '0) && (prev_x > len_reg))
                        begin
                            emit_req           = 1'b1;
                            emit_res.out_index = IDX_W'(len_reg + XW'(1));
                            if (emit_ok)
                            begin
                                term_next  = item_reg.msg_term;
                                voted_next = higher ? '0 : voted_reg;
                                role_next  = ROLE_FOLLOWER;
                                state_next = ST_APPLY;
                            end
                        end
                        else
                        begin
                            term_next  = item_reg.msg_term;
                            voted_next = higher ? '0 : voted_reg;
                            role_next  = ROLE_FOLLOWER;
                            rd_en      = 1'b1;
                            rd_idx     = prev_x;
                            state_next = (prev_x != '0) ? ST_A_PT : ST_A_ENT;
                        end
                    end
                    OP_TIMEOUT:
                    begin
                        if (role_reg == ROLE_LEADER)
                        begin
                            state_next = ST_APPLY;
                        end
                        else
                        begin
                            term_next  = (term_reg != TERM_SAT) ? term_reg + 1'b1 : term_reg;
                            voted_next = own_id;
                            role_next  = ROLE_CANDIDATE;
                            votes_next = ID_W'(1);
                            vmask_next = '0;
                            rd_en      = 1'b1;
                            rd_idx     = len_reg;
                            p_next     = CNT_W'(1);
                            state_next = (maj <= CNT_W'(1)) ? ST_LEAD : ST_VQ_EM;
                        end
                    end
                    OP_VOTE_REP:
                    begin
                        state_next = ST_APPLY;
                        if (higher)
                        begin
                            term_next  = item_reg.msg_term;
                            voted_next = '0;
                            role_next  = ROLE_FOLLOWER;
                        end
                        else if ((role_reg == ROLE_CANDIDATE)
                                 && (item_reg.msg_term == term_reg)
                                 && item_reg.granted && peer_ok
                                 && !vmask_reg[peer_ix])
                        begin
                            vmask_next[peer_ix] = 1'b1;
                            votes_next = votes_reg + 1'b1;
                            if ({1'b0, votes_reg} + CNT_W'(1) >= maj)
                            begin
                                state_next = ST_LEAD;
                            end
                        end
                    end
                    OP_PROPOSE:
                    begin
                        if ((role_reg != ROLE_LEADER) || (len_reg >= XW'(LOG_DEPTH)))
                        begin
                            emit_req      = 1'b1;
                            emit_res.kind = K_PROP_ANS;
                            if (emit_ok)
                            begin
                                state_next = ST_APPLY;
                            end
                        end
                        else
                        begin
                            we            = 1'b1;
                            wr_idx        = len_reg;
                            wr_term       = term_reg;
                            len_next      = len_reg + XW'(1);
                            wi_next       = len_reg + XW'(1);
                            ret_prop_next = 1'b1;
                            state_next    = ST_CM_RD;
                        end
                    end
                    OP_ACK:
                    begin
                        state_next = ST_APPLY;
                        if (higher)
                        begin
                            term_next  = item_reg.msg_term;
                            voted_next = '0;
                            role_next  = ROLE_FOLLOWER;
                        end
                        else if ((role_reg == ROLE_LEADER)
                                 && (item_reg.msg_term == term_reg) && peer_ok)
                        begin
                            if (ack_m > match_reg[peer_ix])
                            begin
                                match_next[peer_ix] = ack_m;
                                nsend_next[peer_ix] = ack_m + XW'(1);
                            end
                            wi_next       = len_reg;
                            ret_prop_next = 1'b0;
                            state_next    = ST_CM_RD;
                        end
                    end
                    OP_TICK:
                    begin
                        p_next     = CNT_W'(1);
                        state_next = (role_reg == ROLE_LEADER) ? ST_SND_RD : ST_APPLY;
                    end
                    default:
                    begin
                        state_next = ST_APPLY;
                    end
                endcase
            end
            ST_V_DO:
            begin
                emit_req      = 1'b1;
                emit_res.kind = K_VOTE_REP;
                emit_res.ok   = (item_reg.msg_term >= term_reg) && (item_reg.peer != '0)
                    && (higher || (voted_reg == '0) || (voted_reg == item_reg.peer))
                    && ((item_reg.ref_term > rterm)
                        || ((item_reg.ref_term == rterm) && (ri_x >= len_reg)));
                if (emit_ok)
                begin
                    if (higher)
                    begin
                        term_next  = item_reg.msg_term;
                        voted_next = '0;
                        role_next  = ROLE_FOLLOWER;
                    end
                    if (emit_res.ok)
                    begin
                        voted_next = item_reg.peer;
                    end
                    state_next = ST_APPLY;
                end
            end
            ST_A_PT:
            begin
                if (rterm != item_reg.ref_term)
                begin
                    ct_next    = rterm;
                    wi_next    = prev_x;
                    state_next = ST_A_BKRD;
                end
                else
                begin
                    state_next = ST_A_ENT;
                end
            end
            ST_A_BKRD:
            begin
                if (wi_reg > XW'(1))
                begin
                    rd_en      = 1'b1;
                    rd_idx     = wi_reg - XW'(1);
                    state_next = ST_A_BK;
                end
                else
                begin
                    emit_req           = 1'b1;
                    emit_res.kind      = K_APPEND_REP;
                    emit_res.out_index = IDX_W'(wi_reg);
                    if (emit_ok)
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_A_BK:
            begin
                if (rterm == ct_reg)
                begin
                    wi_next    = wi_reg - XW'(1);
                    state_next = ST_A_BKRD;
                end
                else
                begin
                    emit_req           = 1'b1;
                    emit_res.kind      = K_APPEND_REP;
                    emit_res.out_index = IDX_W'(wi_reg);
                    if (emit_ok)
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_A_ENT:
            begin
                if (!item_reg.has_entry)
                begin
                    state_next = ST_A_FIN;
                end
                else if (idx_x <= len_reg)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = idx_x;
                    state_next = ST_A_ET;
                end
                else if (len_reg >= XW'(LOG_DEPTH))
                begin
                    emit_req      = 1'b1;
                    emit_res.kind = K_APPEND_REP;
                    if (emit_ok)
                    begin
                        state_next = ST_APPLY;
                    end
                end
                else
                begin
                    we         = 1'b1;
                    wr_idx     = len_reg;
                    len_next   = len_reg + XW'(1);
                    state_next = ST_A_FIN;
                end
            end
            ST_A_ET:
            begin
                if (rterm != item_reg.entry_term)
                begin
                    // A disagreeing entry cuts the log back and takes its place.
                    we       = 1'b1;
                    wr_idx   = prev_x;
                    len_next = idx_x;
                end
                state_next = ST_A_FIN;
            end
            ST_A_FIN:
            begin
                emit_req           = 1'b1;
                emit_res.kind      = K_APPEND_REP;
                emit_res.ok        = 1'b1;
                emit_res.out_index = IDX_W'(lastnew);
                if (emit_ok)
                begin
                    if (lc_x > commit_reg)
                    begin
                        commit_next = (lc_x < lastnew) ? lc_x : lastnew;
                    end
                    state_next = ST_APPLY;
                end
            end
            ST_VQ_EM:
            begin
                if (p_reg > c_nodes)
                begin
                    state_next = ST_APPLY;
                end
                else if (p_reg == own6)
                begin
                    p_next = p_reg + CNT_W'(1);
                end
                else
                begin
                    emit_req           = 1'b1;
                    emit_res.kind      = K_VOTE_REQ;
                    emit_res.out_index = IDX_W'(len_reg);
                    emit_res.out_term  = rterm;
                    emit_res.dest      = ID_W'(p_reg);
                    if (emit_ok)
                    begin
                        p_next = p_reg + CNT_W'(1);
                    end
                end
            end
            ST_LEAD:
            begin
                role_next = ROLE_LEADER;
                for (int k = 0; k < MAX_NODES; k++)
                begin
                    nsend_next[k] = len_reg + XW'(1);
                    match_next[k] = '0;
                end
                p_next     = CNT_W'(1);
                state_next = ST_SND_RD;
            end
            ST_SND_RD:
            begin
                if (p_reg > c_nodes)
                begin
                    state_next = ST_APPLY;
                end
                else if (p_reg == own6)
                begin
                    p_next = p_reg + CNT_W'(1);
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = np_prev;
                    wi_next    = np_prev;
                    state_next = ST_SND_EM;
                end
            end
            ST_SND_EM:
            begin
                emit_req            = 1'b1;
                emit_res.kind       = K_APPEND_REQ;
                emit_res.out_index  = IDX_W'(wi_reg);
                emit_res.out_term   = (wi_reg <= len_reg) ? rterm : '0;
                emit_res.dest       = ID_W'(p_reg);
                emit_res.out_commit = IDX_W'(commit_reg);
                if (emit_ok)
                begin
                    p_next     = p_reg + CNT_W'(1);
                    state_next = ST_SND_RD;
                end
            end
            ST_CM_RD:
            begin
                if (wi_reg > commit_reg)
                begin
                    rd_en       = 1'b1;
                    rd_idx      = wi_reg;
                    cnt_ok_next = (match_cnt + CNT_W'(1)) >= maj;
                    state_next  = ST_CM_CHK;
                end
                else
                begin
                    state_next = ret_prop_reg ? ST_PROP : ST_APPLY;
                end
            end
            ST_CM_CHK:
            begin
                if (cnt_ok_reg && (rterm == term_reg))
                begin
                    commit_next = wi_reg;
                    state_next  = ret_prop_reg ? ST_PROP : ST_APPLY;
                end
                else
                begin
                    wi_next    = wi_reg - XW'(1);
                    state_next = ST_CM_RD;
                end
            end
            ST_PROP:
            begin
                emit_req           = 1'b1;
                emit_res.kind      = K_PROP_ANS;
                emit_res.ok        = 1'b1;
                emit_res.out_index = IDX_W'(len_reg);
                if (emit_ok)
                begin
                    p_next     = CNT_W'(1);
                    state_next = ST_SND_RD;
                end
            end
            ST_APPLY:
            begin
                if ((applied_reg < commit_reg) && (burst_reg < BW'(APPLY_BURST))
                    && (n_reg < CNT_W'(RES_MAX)))
                begin
                    rd_en      = 1'b1;
                    rd_idx     = applied_reg + XW'(1);
                    state_next = ST_AP_EM;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_AP_EM:
            begin
                emit_req             = 1'b1;
                emit_res.kind        = K_APPLY;
                emit_res.out_index   = IDX_W'(applied_reg + XW'(1));
                emit_res.out_payload = rpay;
                if (emit_ok)
                begin
                    applied_next = applied_reg + XW'(1);
                    burst_next   = burst_reg + BW'(1);
                    state_next   = ST_APPLY;
                end
            end
            ST_FIN:
            begin
                flush = 1'b1;
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // One result is held back so the last one of an item can be marked.
    assign store = emit_req && emit_ok && (n_reg < CNT_W'(RES_MAX));
    assign push  = hold_v_reg && ((store) || (flush && can_push));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            term_reg     <= '0;
            voted_reg    <= '0;
            role_reg     <= ROLE_FOLLOWER;
            len_reg      <= '0;
            commit_reg   <= '0;
            applied_reg  <= '0;
            votes_reg    <= '0;
            vmask_reg    <= '0;
            for (int k = 0; k < MAX_NODES; k++)
            begin
                nsend_reg[k] <= XW'(1);
                match_reg[k] <= '0;
            end
            p_reg        <= '0;
            wi_reg       <= '0;
            ct_reg       <= '0;
            ret_prop_reg <= 1'b0;
            cnt_ok_reg   <= 1'b0;
            burst_reg    <= '0;
            n_reg        <= '0;
            hold_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            term_reg     <= term_next;
            voted_reg    <= voted_next;
            role_reg     <= role_next;
            len_reg      <= len_next;
            commit_reg   <= commit_next;
            applied_reg  <= applied_next;
            votes_reg    <= votes_next;
            vmask_reg    <= vmask_next;
            nsend_reg    <= nsend_next;
            match_reg    <= match_next;
            p_reg        <= p_next;
            wi_reg       <= wi_next;
            ct_reg       <= ct_next;
            ret_prop_reg <= ret_prop_next;
            cnt_ok_reg   <= cnt_ok_next;
            burst_reg    <= burst_next;
            if (q_pop)
            begin
                n_reg <= '0;
            end
            else if (store)
            begin
                n_reg <= n_reg + CNT_W'(1);
            end
            if (store)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (push)
            begin
                hold_v_reg <= 1'b0;
            end
            out_v_reg <= push || (out_v_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (store)
        begin
            hold_reg <= emit_res;
        end
        if (push)
        begin
            out_res      <= hold_reg;
            out_term_now <= term_reg;
            out_role     <= role_reg;
            out_last     <= flush;
        end
        if (we)
        begin
            term_mem[AW'(wr_idx)] <= wr_term;
            pay_mem[AW'(wr_idx)]  <= wr_pay;
        end
        if (rd_en)
        begin
            rd_term_reg <= term_mem[AW'(rd_idx - XW'(1))];
            rd_pay_reg  <= pay_mem[AW'(rd_idx - XW'(1))];
            rd_zero_reg <= (rd_idx == '0) || (rd_idx > XW'(LOG_DEPTH));
        end
    end

    assign out_valid = out_v_reg;

endmodule

// ----- src/crep_checker.sv -----
`timescale 1ns / 1ps
module crep_checker
    import crep_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [2:0]       kind,
    input logic             ok,
    input logic [ID_W-1:0]  dest,
    input logic [1:0]       role,
    input logic             last
);

    // A stalled result beat keeps its kind and last flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
        else $error("result beat changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == K_VOTE_REP) || (kind == K_APPEND_REP)
            || (kind == K_APPLY) || (kind == K_APPEND_REQ)
            || (kind == K_VOTE_REQ) || (kind == K_PROP_ANS))
        else $error("result kind out of range");

    a_ok_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == K_APPLY) || (kind == K_APPEND_REQ)
            || (kind == K_VOTE_REQ)) |-> !ok)
        else $error("ok set on a request or apply beat");

    a_dest_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != K_APPEND_REQ) && (kind != K_VOTE_REQ) |-> dest == '0)
        else $error("destination set on a reply beat");

    // Append requests to peers are sent only by a leader.
    a_req_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_APPEND_REQ) |-> role == ROLE_LEADER)
        else $error("append request from a non-leader");

endmodule

bind consensus_replica_engine_unit crep_checker u_crep_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .ok        (ok),
    .dest      (dest),
    .role      (role),
    .last      (last)
);
